// ----- rtl/i2a_pkg.sv -----
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types, character codes and format selector codes for the integer
// to ASCII formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

   // format selector codes (the unused code falls back to unsigned decimal)
   localparam logic [1:0] KIND_UDEC = 2'd0;
   localparam logic [1:0] KIND_HEX  = 2'd1;
   localparam logic [1:0] KIND_SDEC = 2'd2;

   // ASCII codes
   localparam logic [6:0] CHAR_ZERO  = 7'h30;
   localparam logic [6:0] CHAR_A_LC  = 7'h61;
   localparam logic [6:0] CHAR_X_LC  = 7'h78;
   localparam logic [6:0] CHAR_MINUS = 7'h2D;

   localparam int DIGIT_BITS = 4;

   // per-cycle operation of every digit cell
   typedef enum logic [1:0] {
      CELL_HOLD  = 2'd0,
      CELL_CLEAR = 2'd1,
      CELL_SHIFT = 2'd2,
      CELL_EMIT  = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        dec;   // apply the add-3 correction (decimal mode)
   } cell_ctrl_type;

   function automatic logic [6:0] digit_char(input logic [DIGIT_BITS-1:0] d);
      logic [6:0] d7;
      d7 = {3'b000, d};
      if (d < 4'd10) begin
         digit_char = CHAR_ZERO + d7;
      end else begin
         digit_char = CHAR_A_LC + d7 - 7'd10;
      end
   endfunction

endpackage

// ----- rtl/i2a_digit_cell.sv -----
// ----------------------------------------------------------------------------
// i2a_digit_cell
// One digit of the conversion chain: a shift-and-add-3 cell in decimal
// mode, a plain nibble shifter in hex mode, and a digit mover when the
// text is being read out.
// ----------------------------------------------------------------------------
module i2a_digit_cell
   import i2a_pkg::*;
(
   input  logic                  clock,
   input  cell_ctrl_type         ctrl,
   input  logic                  shift_in,
   input  logic [DIGIT_BITS-1:0] load_digit,
   output logic [DIGIT_BITS-1:0] digit,
   output logic                  carry_out
);

   logic [DIGIT_BITS-1:0] digit_ff;
   logic [DIGIT_BITS-1:0] digit_in;
   logic [DIGIT_BITS-1:0] corr;

   always_comb begin
      corr      = (ctrl.dec && (digit_ff >= 4'd5)) ? digit_ff + 4'd3 : digit_ff;
      carry_out = corr[DIGIT_BITS-1];
      case (ctrl.op)
         CELL_CLEAR: digit_in = '0;
         CELL_SHIFT: digit_in = {corr[DIGIT_BITS-2:0], shift_in};
         CELL_EMIT:  digit_in = load_digit;
         default:    digit_in = digit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit = digit_ff;

endmodule

// ----- rtl/integer_to_ascii_formatter.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Prints a binary value as unsigned decimal, signed decimal or 0x-prefixed
// lower-case hex, one ASCII character per output transaction, most
// significant first, with last set on the final character.
// ----------------------------------------------------------------------------
// Sequence: load the request, convert it bit-serially through the digit
//   chain, then send the prefix characters if any, drop the leading zeros
//   and send the digits; prefix and digit output wait while the output
//   stalls. A new value is taken only once the last character of the
//   previous one is in the output register.
// Reset: synchronous, active high; clears the sequencer and output valid.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter
   import i2a_pkg::*;
#(
   parameter int VALUE_BITS = 64
)
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [63:0] req_value,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_ascii_char,
   output logic        rsp_last
);

   // Number of decimal digits of 2^VALUE_BITS - 1 (log10(2) ~ 0.30103).
   // Enough room for the hex digits as well.
   localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
   localparam int DIG_CNT_W  = $clog2(DEC_DIGITS + 1);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_CONVERT = 5'b00010,
      ST_PREFIX  = 5'b00100,
      ST_SKIP    = 5'b01000,
      ST_DIGITS  = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   logic [VALUE_BITS-1:0]   value_ff, value_in;
   logic [BIT_CNT_W-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]    dig_cnt_ff, dig_cnt_in;
   logic                    hex_ff, hex_in;
   logic                    neg_ff, neg_in;
   logic                    pfx_second_ff, pfx_second_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [6:0]              rsp_char_ff, rsp_char_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    req_take;
   logic                    slot_free;
   logic [VALUE_BITS-1:0]   in_value;
   logic                    in_hex;
   logic                    in_neg;
   cell_ctrl_type           cell_ctrl;

   logic [DIGIT_BITS-1:0]   digits [DEC_DIGITS];
   logic                    carries [DEC_DIGITS];
   logic [DIGIT_BITS-1:0]   top_digit;

   // -------------------------------------------------------------------------
   // Digit chain: cell 0 takes the binary MSB, each cell passes its corrected
   // top bit up; in read-out each digit moves up a cell and cell 0 gets zero.
   // -------------------------------------------------------------------------
   for (genvar i = 0; i < DEC_DIGITS; i++) begin : g_cell
      logic                  sh_in;
      logic [DIGIT_BITS-1:0] ld;
      if (i == 0) begin : g_first
         assign sh_in = value_ff[VALUE_BITS-1];
         assign ld    = '0;
      end else begin : g_rest
         assign sh_in = carries[i-1];
         assign ld    = digits[i-1];
      end
      i2a_digit_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .shift_in   (sh_in),
         .load_digit (ld),
         .digit      (digits[i]),
         .carry_out  (carries[i])
      );
   end

   assign top_digit = digits[DEC_DIGITS-1];

   // -------------------------------------------------------------------------
   // Request decode
   // -------------------------------------------------------------------------
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign in_hex    = (req_kind == KIND_HEX);
   assign in_neg    = (req_kind == KIND_SDEC) && req_value[VALUE_BITS-1];
   // Two's complement magnitude; the most negative value maps onto itself,
   // which read as unsigned is the right magnitude.
   assign in_value  = in_neg ? ('0 - req_value[VALUE_BITS-1:0])
                             : req_value[VALUE_BITS-1:0];

   // output register is free when empty or being taken this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // -------------------------------------------------------------------------
   // Sequencer
   // -------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      value_in      = value_ff;
      bit_cnt_in    = bit_cnt_ff;
      dig_cnt_in    = dig_cnt_ff;
      hex_in        = hex_ff;
      neg_in        = neg_ff;
      pfx_second_in = pfx_second_ff;
      cell_ctrl.op  = CELL_HOLD;
      cell_ctrl.dec = !hex_ff;

      rsp_valid_in  = slot_free ? 1'b0 : rsp_valid_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               value_in      = in_value;
               hex_in        = in_hex;
               neg_in        = in_neg;
               pfx_second_in = 1'b0;
               bit_cnt_in    = BIT_CNT_W'(VALUE_BITS - 1);
               cell_ctrl.op  = CELL_CLEAR;
               state_in      = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cell_ctrl.op = CELL_SHIFT;
            value_in     = {value_ff[VALUE_BITS-2:0], 1'b0};
            bit_cnt_in   = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == '0) begin
               dig_cnt_in = DIG_CNT_W'(DEC_DIGITS);
               state_in   = (hex_ff || neg_ff) ? ST_PREFIX : ST_SKIP;
            end
         end
         ST_PREFIX: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b0;
               if (neg_ff) begin
                  rsp_char_in = CHAR_MINUS;
                  state_in    = ST_SKIP;
               end else if (!pfx_second_ff) begin
                  rsp_char_in   = CHAR_ZERO;
                  pfx_second_in = 1'b1;
               end else begin
                  rsp_char_in = CHAR_X_LC;
                  state_in    = ST_SKIP;
               end
            end
         end
         ST_SKIP: begin
            // drop leading zeros, always keep the units digit
            if ((top_digit == '0) && (dig_cnt_ff != DIG_CNT_W'(1))) begin
               cell_ctrl.op = CELL_EMIT;
               dig_cnt_in   = dig_cnt_ff - 1'b1;
            end else begin
               state_in = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = digit_char(top_digit);
               rsp_last_in  = (dig_cnt_ff == DIG_CNT_W'(1));
               cell_ctrl.op = CELL_EMIT;
               dig_cnt_in   = dig_cnt_ff - 1'b1;
               if (dig_cnt_ff == DIG_CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      bit_cnt_ff    <= bit_cnt_in;
      dig_cnt_ff    <= dig_cnt_in;
      hex_ff        <= hex_in;
      neg_ff        <= neg_in;
      pfx_second_ff <= pfx_second_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_char = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;

endmodule
